[rtl/core/cmm_pkg.sv]
// Shared types and constants of the complex matrix multiplier.
`timescale 1ns / 1ps

package cmm_pkg;

  localparam int N_DEF  = 4;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 3;
  localparam int ELEM_W = 16;
  localparam int FRAC_W = 4;
  localparam int WORD_W = 2 * ELEM_W;

  localparam logic [FRAC_W-1:0] FRAC_RST = 4'd13;

  localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;

  // Which partial product the shared multiplier forms this cycle.
  typedef enum logic [1:0] {
    PH_RR,
    PH_II,
    PH_RI,
    PH_IR
  } phase_t;

  typedef struct packed {
    logic   clear;
    logic   mul_en;
    phase_t phase;
    logic   round_en;
  } mac_ctl_t;

endpackage

[rtl/core/complex_matrix_multiply.sv]
// Top level of the complex matrix multiplier: command decode, sequencer, stores.
//
// Usage. Three valid/ready channels. The cfg channel writes frac_bits (reset 13),
// the fixed-point fraction width and right shift applied to every sum; write it
// only while the block is idle. The input channel takes commands: write an
// element of A or B (cmd, row, col, elem_re, elem_im), or run the product.
// Element writes are taken one per cycle while the block is idle; writes
// outside the N by N grid and the unused command code are dropped. A run makes
// in_ready fall until the last of the N*N product words, row-major, has gone
// into the output register; last marks the final one.
// For each product word, every k takes a store read and four partial products on
// the one shared 16x16 multiplier, then drain, round and emit.
// The output is one register: a stalled receiver holds the current word and
// the sequencer waits in its emit step. Reset clears control state and sets
// frac_bits to 13; store contents stay undefined until written, and a run
// must not read an element that was never written.
`timescale 1ns / 1ps

module complex_matrix_multiply #(
  parameter int N = cmm_pkg::N_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmm_pkg::FRAC_W-1:0]        frac_bits,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cmm_pkg::CMD_W-1:0]         cmd,
  input  logic [cmm_pkg::IDX_W-1:0]         row,
  input  logic [cmm_pkg::IDX_W-1:0]         col,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_re,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_im,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cmm_pkg::IDX_W-1:0]         out_row,
  output logic [cmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [cmm_pkg::ELEM_W-1:0] prod_re,
  output logic signed [cmm_pkg::ELEM_W-1:0] prod_im,
  output logic                              saturated,
  output logic                              last
);
  import cmm_pkg::*;

  localparam int ELEMS = N * N;
  localparam int AW    = $clog2(ELEMS);
  localparam int IW    = $clog2(N);
  localparam int ACC_W = 33 + $clog2(N);
  localparam logic [IDX_W:0] N_LIM = (IDX_W+1)'(N);
  localparam logic [IW-1:0]  I_MAX = IW'(N - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DRAIN,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t          state;
  logic [FRAC_W-1:0] frac;
  logic [IW-1:0]   r_idx, c_idx, k_idx;
  phase_t          phase;

  logic            in_acc, in_range, run_go, emit_go;
  logic            we_a, we_b;
  logic [AW-1:0]   waddr, a_raddr, b_raddr;
  logic [WORD_W-1:0] wdata, a_word, b_word;
  mac_ctl_t        ctl;
  logic signed [ELEM_W-1:0] res_re, res_im;
  logic            res_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = ({1'b0, row} < N_LIM) && ({1'b0, col} < N_LIM);
  assign we_a      = in_acc && in_range && (cmd == CMD_WR_A);
  assign we_b      = in_acc && in_range && (cmd == CMD_WR_B);
  assign run_go    = in_acc && (cmd == CMD_RUN);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);
  assign waddr     = AW'(int'(row) * N + int'(col));
  assign wdata     = {elem_re, elem_im};
  assign a_raddr   = AW'(int'(r_idx) * N + int'(k_idx));
  assign b_raddr   = AW'(int'(k_idx) * N + int'(c_idx));

  always_comb begin
    ctl.clear    = run_go || emit_go;
    ctl.mul_en   = (state == S_MUL);
    ctl.phase    = phase;
    ctl.round_en = (state == S_ROUND);
  end

  cmm_ram #(.WIDTH(WORD_W), .DEPTH(ELEMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_word)
  );

  cmm_ram #(.WIDTH(WORD_W), .DEPTH(ELEMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_word)
  );

  cmm_mac #(.ACC_W(ACC_W)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .a_word  (a_word),
    .b_word  (b_word),
    .frac    (frac),
    .res_re  (res_re),
    .res_im  (res_im),
    .res_sat (res_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frac      <= FRAC_RST;
      r_idx     <= '0;
      c_idx     <= '0;
      k_idx     <= '0;
      phase     <= PH_RR;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frac <= frac_bits;
      end
      // refill from the emit step, else drop the word once taken
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (run_go) begin
            r_idx <= '0;
            c_idx <= '0;
            k_idx <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          phase <= PH_RR;
          state <= S_MUL;
        end
        S_MUL: begin
          if (phase == PH_IR) begin
            phase <= PH_RR;
            if (k_idx == I_MAX) begin
              k_idx <= '0;
              state <= S_DRAIN;
            end else begin
              k_idx <= k_idx + 1'b1;
              state <= S_LOAD;
            end
          end else begin
            phase <= phase_t'(phase + 1'b1);
          end
        end
        S_DRAIN: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_row   <= IDX_W'(r_idx);
            out_col   <= IDX_W'(c_idx);
            prod_re   <= res_re;
            prod_im   <= res_im;
            saturated <= res_sat;
            last      <= (r_idx == I_MAX) && (c_idx == I_MAX);
            if (c_idx == I_MAX) begin
              c_idx <= '0;
              if (r_idx == I_MAX) begin
                r_idx <= '0;
                state <= S_IDLE;
              end else begin
                r_idx <= r_idx + 1'b1;
                state <= S_LOAD;
              end
            end else begin
              c_idx <= c_idx + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/cmm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cmm_mac.sv]
// Shared complex multiply-accumulate unit with rounding and saturation.
`timescale 1ns / 1ps

module cmm_mac #(
  parameter int ACC_W = 35
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cmm_pkg::mac_ctl_t               ctl,
  input  logic [cmm_pkg::WORD_W-1:0]      a_word,
  input  logic [cmm_pkg::WORD_W-1:0]      b_word,
  input  logic [cmm_pkg::FRAC_W-1:0]      frac,
  output logic signed [cmm_pkg::ELEM_W-1:0] res_re,
  output logic signed [cmm_pkg::ELEM_W-1:0] res_im,
  output logic                            res_sat
);
  import cmm_pkg::*;

  localparam int PROD_W = 2 * ELEM_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32'sd32768);

  logic signed [ELEM_W-1:0] ar, ai, br, bi;
  logic signed [ELEM_W-1:0] op_x, op_y;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  phase_t                   prod_op;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic signed [ACC_W-1:0]  rnd_re, rnd_im;
  logic signed [ACC_W-1:0]  half;
  logic [ELEM_W:0]          clip_re, clip_im;

  assign ar = a_word[WORD_W-1:ELEM_W];
  assign ai = a_word[ELEM_W-1:0];
  assign br = b_word[WORD_W-1:ELEM_W];
  assign bi = b_word[ELEM_W-1:0];

  always_comb begin
    case (ctl.phase)
      PH_RR: begin op_x = ar; op_y = br; end
      PH_II: begin op_x = ai; op_y = bi; end
      PH_RI: begin op_x = ar; op_y = bi; end
      PH_IR: begin op_x = ai; op_y = br; end
      default: begin op_x = ar; op_y = br; end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign half = (frac == '0) ? '0 : (ACC_W'(1) << (frac - 4'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mul_en;
    end
    if (ctl.mul_en) begin
      prod    <= op_x * op_y;
      prod_op <= ctl.phase;
    end
    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (prod_vld) begin
      case (prod_op)
        PH_RR: acc_re <= acc_re + prod_ext;
        PH_II: acc_re <= acc_re - prod_ext;
        PH_RI: acc_im <= acc_im + prod_ext;
        PH_IR: acc_im <= acc_im + prod_ext;
        default: acc_re <= acc_re;
      endcase
    end
    if (ctl.round_en) begin
      rnd_re <= acc_re + half;
      rnd_im <= acc_im + half;
    end
  end

  // Floor-shift the biased sum, then clip; top bit of the result is the clip flag.
  function automatic logic [ELEM_W:0] scale_clip(input logic signed [ACC_W-1:0] v,
                                                 input logic [FRAC_W-1:0] sh);
    logic signed [ACC_W-1:0] s;
    s = v >>> sh;
    if (s > SAT_HI) begin
      scale_clip = {1'b1, 16'h7FFF};
    end else if (s < SAT_LO) begin
      scale_clip = {1'b1, 16'h8000};
    end else begin
      scale_clip = {1'b0, s[ELEM_W-1:0]};
    end
  endfunction

  assign clip_re = scale_clip(rnd_re, frac);
  assign clip_im = scale_clip(rnd_im, frac);
  assign res_re  = clip_re[ELEM_W-1:0];
  assign res_im  = clip_im[ELEM_W-1:0];
  assign res_sat = clip_re[ELEM_W] | clip_im[ELEM_W];

endmodule

[rtl/core/cmm_checker.sv]
// Port-level checks of the complex matrix multiplier, bound to the top level.
`timescale 1ns / 1ps

module cmm_checker #(
  parameter int N = cmm_pkg::N_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [cmm_pkg::CMD_W-1:0]         cmd,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cmm_pkg::IDX_W-1:0]         out_row,
  input logic [cmm_pkg::IDX_W-1:0]         out_col,
  input logic signed [cmm_pkg::ELEM_W-1:0] prod_re,
  input logic signed [cmm_pkg::ELEM_W-1:0] prod_im,
  input logic                              saturated,
  input logic                              last
);
  import cmm_pkg::*;

  localparam logic [IDX_W-1:0] I_MAX = IDX_W'(N - 1);

  // hold a stalled product word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prod_re) && $stable(prod_im)
      && $stable(out_row) && $stable(out_col) && $stable(saturated) && $stable(last))
    else $error("stalled product word changed");

  // a run command closes the input until the run ends
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_RUN) |=> !in_ready)
    else $error("input taken right after a run command");

  // last only on the corner element
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (out_row == I_MAX) && (out_col == I_MAX))
    else $error("last flag away from the final element");

  // block stays busy between words of a run
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input open in the middle of a run");

endmodule

bind complex_matrix_multiply cmm_checker #(.N(N)) u_cmm_checker (.*);
